FILE: rtl/epoch_to_local_civil_time_defines.svh
// Assertion macros for the epoch to local civil time checker.
// Standalone header; no other file is needed.
`ifndef EPOCH_TO_LOCAL_CIVIL_TIME_DEFINES_SVH
`define EPOCH_TO_LOCAL_CIVIL_TIME_DEFINES_SVH

// check a property at each clock edge outside reset
`define E2LCT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property at each clock edge, reset included
`define E2LCT_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/e2lct_pkg.sv
// Shared types, constants and lookup functions for the epoch to local civil time block.
// No dependencies.
package e2lct_pkg;

   localparam int NOW_STAGES   = 2;
   localparam int SPLIT_STAGES = 6;
   localparam int CIVIL_STAGES = 6;
   localparam int LOCAL_STAGES = 4;

   localparam int CSR_WIDTH       = 5;
   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_UTC_OFFSET  = 2'd0,
      CSR_DST_ENABLE  = 2'd1,
      CSR_TWELVE_HOUR = 2'd2
   } csr_index_type;

   localparam logic [4:0] OFFSET_RESET = 5'b11010;

   localparam logic [29:0] MS_RECIP        = 30'd549755814;
   localparam logic [25:0] DAY_RECIP       = 26'd50903317;
   localparam logic [13:0] HOUR_RECIP      = 14'd9321;
   localparam logic [10:0] MIN_RECIP       = 11'd1093;
   localparam logic [16:0] Q1460_RECIP     = 17'd91930;
   localparam logic [18:0] YOE_RECIP       = 19'd367720;
   localparam logic [11:0] MP_RECIP        = 12'd3427;
   localparam logic [12:0] MOD7_RECIP      = 13'd4682;
   localparam logic [10:0] Q100_RECIP      = 11'd1311;

   localparam logic [16:0] SECONDS_PER_DAY  = 17'd86400;
   localparam logic [11:0] SECONDS_PER_HOUR = 12'd3600;
   localparam logic [5:0]  SECONDS_PER_MIN  = 6'd60;
   localparam logic [19:0] DAY_SHIFT        = 20'd719468;
   localparam logic [17:0] CENTURY_DAYS     = 18'd36524;
   localparam logic [17:0] ERA_LAST_DAY     = 18'd146096;
   localparam int          ERA_MAX          = 5;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_MAR = 4'd3;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_OCT = 4'd10;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic signed [4:0] utc_offset_hours;
      logic              dst_enable;
      logic              twelve_hour_mode;
   } cfg_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } clock_type;

   typedef struct packed {
      logic [15:0] days;
      clock_type   tod;
   } split_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      clock_type   tod;
   } civil_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        pm;
      logic        dst_active;
   } result_type;

   function automatic logic [19:0] era_base(input logic [2:0] era);
      case (era)
         3'd0:    return 20'd0;
         3'd1:    return 20'd146097;
         3'd2:    return 20'd292194;
         3'd3:    return 20'd438291;
         3'd4:    return 20'd584388;
         3'd5:    return 20'd730485;
         default: return 20'd0;
      endcase
   endfunction

   function automatic logic [11:0] era_years(input logic [2:0] era);
      case (era)
         3'd0:    return 12'd0;
         3'd1:    return 12'd400;
         3'd2:    return 12'd800;
         3'd3:    return 12'd1200;
         3'd4:    return 12'd1600;
         3'd5:    return 12'd2000;
         default: return 12'd0;
      endcase
   endfunction

   // first day of year (March based) for each month index
   function automatic logic [8:0] mp_start(input logic [3:0] mp);
      case (mp)
         4'd0:    return 9'd0;
         4'd1:    return 9'd31;
         4'd2:    return 9'd61;
         4'd3:    return 9'd92;
         4'd4:    return 9'd122;
         4'd5:    return 9'd153;
         4'd6:    return 9'd184;
         4'd7:    return 9'd214;
         4'd8:    return 9'd245;
         4'd9:    return 9'd275;
         4'd10:   return 9'd306;
         4'd11:   return 9'd337;
         default: return 9'd0;
      endcase
   endfunction

   function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
      case (month)
         4'd1:    return 5'd31;
         4'd2:    return leap ? 5'd29 : 5'd28;
         4'd3:    return 5'd31;
         4'd4:    return 5'd30;
         4'd5:    return 5'd31;
         4'd6:    return 5'd30;
         4'd7:    return 5'd31;
         4'd8:    return 5'd31;
         4'd9:    return 5'd30;
         4'd10:   return 5'd31;
         4'd11:   return 5'd30;
         4'd12:   return 5'd31;
         default: return 5'd31;
      endcase
   endfunction

endpackage

FILE: rtl/epoch_to_local_civil_time.sv
// Unix epoch plus elapsed milliseconds to local civil date and time, 18-stage pipeline.
// One item per cycle sustained while rsp_stall is low, set by the per-stage valid and
// stall chain (each stage loads when the next can move).
// Synchronous reset empties every stage and loads the register defaults:
// offset -6 hours, daylight saving on, twelve-hour form on.
module epoch_to_local_civil_time
   import e2lct_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [31:0]                req_sync_epoch,
   input  logic [31:0]                req_elapsed_ms,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [11:0]                rsp_year,
   output logic [3:0]                 rsp_month,
   output logic [4:0]                 rsp_day,
   output logic [4:0]                 rsp_hour,
   output logic [5:0]                 rsp_minute,
   output logic [5:0]                 rsp_second,
   output logic                       rsp_pm,
   output logic                       rsp_dst_active,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]       csr_write_data
);

   cfg_type    cfg_ff, cfg_in;
   logic       now_valid, now_stall;
   logic [31:0] now;
   logic       split_valid, split_stall;
   split_type  split;
   logic       civil_valid, civil_stall;
   civil_type  civil;
   result_type result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_UTC_OFFSET:  cfg_in.utc_offset_hours = csr_write_data;
            CSR_DST_ENABLE:  cfg_in.dst_enable       = csr_write_data[0];
            CSR_TWELVE_HOUR: cfg_in.twelve_hour_mode = csr_write_data[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.utc_offset_hours <= OFFSET_RESET;
         cfg_ff.dst_enable       <= 1'b1;
         cfg_ff.twelve_hour_mode <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   e2lct_now u_now (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .sync_epoch (req_sync_epoch),
      .elapsed_ms (req_elapsed_ms),
      .out_valid  (now_valid),
      .out_stall  (now_stall),
      .now        (now)
   );

   e2lct_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (now_valid),
      .in_stall  (now_stall),
      .now       (now),
      .out_valid (split_valid),
      .out_stall (split_stall),
      .split     (split)
   );

   e2lct_civil u_civil (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_stall  (split_stall),
      .split     (split),
      .out_valid (civil_valid),
      .out_stall (civil_stall),
      .civil     (civil)
   );

   e2lct_local u_local (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (civil_valid),
      .in_stall  (civil_stall),
      .civil     (civil),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .result    (result)
   );

   assign rsp_year       = result.year;
   assign rsp_month      = result.month;
   assign rsp_day        = result.day;
   assign rsp_hour       = result.hour;
   assign rsp_minute     = result.minute;
   assign rsp_second     = result.second;
   assign rsp_pm         = result.pm;
   assign rsp_dst_active = result.dst_active;

endmodule

FILE: rtl/e2lct_now.sv
// Current epoch stages: whole seconds of the elapsed count added to the sync epoch.
// Depends on e2lct_pkg.
module e2lct_now
   import e2lct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_stall,
   input  logic [31:0] sync_epoch,
   input  logic [31:0] elapsed_ms,
   output logic        out_valid,
   input  logic        out_stall,
   output logic [31:0] now
);

   logic [NOW_STAGES-1:0] valid_ff, valid_in, hold;
   logic [58:0] ms_prod;
   logic [22:0] ms_sec_ff;
   logic [31:0] epoch_ff;
   logic [31:0] now_ff;

   always_comb begin
      hold[NOW_STAGES-1] = valid_ff[NOW_STAGES-1] & out_stall;
      for (int i = NOW_STAGES - 2; i >= 0; i--) begin
         hold[i] = valid_ff[i] & hold[i+1];
      end
      valid_in = (hold & valid_ff) | (~hold & {valid_ff[NOW_STAGES-2:0], in_valid});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // divide milliseconds by 1000 as (ms / 8) / 125 through a reciprocal
   assign ms_prod = 59'(elapsed_ms[31:3]) * 59'(MS_RECIP);

   always_ff @(posedge clock) begin
      if (!hold[0]) begin
         epoch_ff  <= sync_epoch;
         ms_sec_ff <= ms_prod[58:36];
      end
      if (!hold[1]) begin
         now_ff <= epoch_ff + {9'b0, ms_sec_ff};
      end
   end

   assign in_stall  = hold[0];
   assign out_valid = valid_ff[NOW_STAGES-1];
   assign now       = now_ff;

endmodule

FILE: rtl/e2lct_split.sv
// Day count and time of day stages: splits the epoch into days, hour, minute, second.
// Depends on e2lct_pkg.
module e2lct_split
   import e2lct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_stall,
   input  logic [31:0] now,
   output logic        out_valid,
   input  logic        out_stall,
   output split_type   split
);

   logic [SPLIT_STAGES-1:0] valid_ff, valid_in, hold;

   logic [50:0] day_prod;
   logic [32:0] day_secs;
   logic [26:0] hour_prod;
   logic [16:0] hour_secs;
   logic [20:0] min_prod;
   logic [11:0] min_secs;

   logic [15:0] days0_ff, days1_ff, days2_ff, days3_ff, days4_ff;
   logic [16:0] low0_ff;
   logic [16:0] sod1_ff;
   logic [11:0] sod2_ff;
   logic [4:0]  hour2_ff, hour3_ff, hour4_ff;
   logic [11:0] rem3_ff;
   logic [5:0]  rem4_ff;
   logic [5:0]  min4_ff;
   split_type   split_in, split_ff;

   always_comb begin
      hold[SPLIT_STAGES-1] = valid_ff[SPLIT_STAGES-1] & out_stall;
      for (int i = SPLIT_STAGES - 2; i >= 0; i--) begin
         hold[i] = valid_ff[i] & hold[i+1];
      end
      valid_in = (hold & valid_ff) | (~hold & {valid_ff[SPLIT_STAGES-2:0], in_valid});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign day_prod  = 51'(now[31:7]) * 51'(DAY_RECIP);
   assign day_secs  = 33'(days0_ff) * 33'(SECONDS_PER_DAY);
   assign hour_prod = 27'(sod1_ff[16:4]) * 27'(HOUR_RECIP);
   assign hour_secs = 17'(hour2_ff) * 17'(SECONDS_PER_HOUR);
   assign min_prod  = 21'(rem3_ff[11:2]) * 21'(MIN_RECIP);
   assign min_secs  = 12'(min4_ff) * 12'(SECONDS_PER_MIN);

   always_comb begin
      split_in.days       = days4_ff;
      split_in.tod.hour   = hour4_ff;
      split_in.tod.minute = min4_ff;
      split_in.tod.second = rem4_ff - min_secs[5:0];
   end

   always_ff @(posedge clock) begin
      if (!hold[0]) begin
         days0_ff <= day_prod[50:35];
         low0_ff  <= now[16:0];
      end
      if (!hold[1]) begin
         days1_ff <= days0_ff;
         sod1_ff  <= low0_ff - day_secs[16:0];
      end
      if (!hold[2]) begin
         days2_ff <= days1_ff;
         sod2_ff  <= sod1_ff[11:0];
         hour2_ff <= hour_prod[25:21];
      end
      if (!hold[3]) begin
         days3_ff <= days2_ff;
         hour3_ff <= hour2_ff;
         rem3_ff  <= sod2_ff - hour_secs[11:0];
      end
      if (!hold[4]) begin
         days4_ff <= days3_ff;
         hour4_ff <= hour3_ff;
         min4_ff  <= min_prod[19:14];
         rem4_ff  <= rem3_ff[5:0];
      end
      if (!hold[5]) begin
         split_ff <= split_in;
      end
   end

   assign in_stall  = hold[0];
   assign out_valid = valid_ff[SPLIT_STAGES-1];
   assign split     = split_ff;

endmodule

FILE: rtl/e2lct_civil.sv
// Civil date stages: Gregorian year, month and day from the day count.
// Depends on e2lct_pkg.
module e2lct_civil
   import e2lct_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_stall,
   input  split_type split,
   output logic      out_valid,
   input  logic      out_stall,
   output civil_type civil
);

   logic [CIVIL_STAGES-1:0] valid_ff, valid_in, hold;

   logic [19:0] z_c;
   logic [2:0]  era_c;
   logic [19:0] doe_c;
   logic [32:0] a_prod;
   logic [2:0]  b_c;
   logic [17:0] t_c;
   logic [36:0] yoe_prod;
   logic [1:0]  cent_c;
   logic [17:0] yoe_days;
   logic [17:0] doy_c;
   logic [10:0] num_c;
   logic [22:0] mp_prod;
   logic [8:0]  day_c;

   logic [2:0]  era0_ff, era1_ff, era2_ff, era3_ff, era4_ff;
   logic [17:0] doe0_ff, doe1_ff, doe2_ff;
   logic [17:0] t1_ff;
   logic [8:0]  yoe2_ff, yoe3_ff, yoe4_ff;
   logic [8:0]  doy3_ff, doy4_ff;
   logic [3:0]  mp4_ff;
   clock_type   tod0_ff, tod1_ff, tod2_ff, tod3_ff, tod4_ff;
   civil_type   civil_in, civil_ff;

   always_comb begin
      hold[CIVIL_STAGES-1] = valid_ff[CIVIL_STAGES-1] & out_stall;
      for (int i = CIVIL_STAGES - 2; i >= 0; i--) begin
         hold[i] = valid_ff[i] & hold[i+1];
      end
      valid_in = (hold & valid_ff) | (~hold & {valid_ff[CIVIL_STAGES-2:0], in_valid});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      z_c   = 20'(split.days) + DAY_SHIFT;
      era_c = '0;
      for (int k = 1; k <= ERA_MAX; k++) begin
         if (z_c >= era_base(3'(k))) begin
            era_c = 3'(k);
         end
      end
      doe_c = z_c - era_base(era_c);
   end

   assign a_prod = 33'(doe0_ff[17:2]) * 33'(Q1460_RECIP);

   always_comb begin
      b_c = 3'(doe0_ff >= CENTURY_DAYS) + 3'(doe0_ff >= 18'(2 * CENTURY_DAYS))
          + 3'(doe0_ff >= 18'(3 * CENTURY_DAYS)) + 3'(doe0_ff >= ERA_LAST_DAY);
      t_c = doe0_ff - 18'(a_prod[32:25]) + 18'(b_c) - 18'(doe0_ff == ERA_LAST_DAY);
   end

   assign yoe_prod = 37'(t1_ff) * 37'(YOE_RECIP);

   always_comb begin
      cent_c   = 2'(yoe2_ff >= 9'd100) + 2'(yoe2_ff >= 9'd200) + 2'(yoe2_ff >= 9'd300);
      yoe_days = 18'(yoe2_ff) * 18'(365) + 18'(yoe2_ff[8:2]) - 18'(cent_c);
      doy_c    = doe2_ff - yoe_days;
   end

   assign num_c   = ({2'b0, doy3_ff} << 2) + {2'b0, doy3_ff} + 11'd2;
   assign mp_prod = 23'(num_c) * 23'(MP_RECIP);

   always_comb begin
      day_c          = doy4_ff - mp_start(mp4_ff) + 9'd1;
      civil_in.day   = day_c[4:0];
      civil_in.month = (mp4_ff < 4'd10) ? mp4_ff + 4'd3 : mp4_ff - 4'd9;
      civil_in.year  = 12'(yoe4_ff) + era_years(era4_ff)
                     + 12'(civil_in.month <= MONTH_FEB);
      civil_in.tod   = tod4_ff;
   end

   always_ff @(posedge clock) begin
      if (!hold[0]) begin
         era0_ff <= era_c;
         doe0_ff <= doe_c[17:0];
         tod0_ff <= split.tod;
      end
      if (!hold[1]) begin
         era1_ff <= era0_ff;
         doe1_ff <= doe0_ff;
         t1_ff   <= t_c;
         tod1_ff <= tod0_ff;
      end
      if (!hold[2]) begin
         era2_ff <= era1_ff;
         doe2_ff <= doe1_ff;
         yoe2_ff <= yoe_prod[35:27];
         tod2_ff <= tod1_ff;
      end
      if (!hold[3]) begin
         era3_ff <= era2_ff;
         yoe3_ff <= yoe2_ff;
         doy3_ff <= doy_c[8:0];
         tod3_ff <= tod2_ff;
      end
      if (!hold[4]) begin
         era4_ff <= era3_ff;
         yoe4_ff <= yoe3_ff;
         doy4_ff <= doy3_ff;
         mp4_ff  <= mp_prod[22:19];
         tod4_ff <= tod3_ff;
      end
      if (!hold[5]) begin
         civil_ff <= civil_in;
      end
   end

   assign in_stall  = hold[0];
   assign out_valid = valid_ff[CIVIL_STAGES-1];
   assign civil     = civil_ff;

endmodule

FILE: rtl/e2lct_local.sv
// Local time stages: daylight saving decision, hour offset with day carry, 12-hour form.
// Depends on e2lct_pkg; the last stage is the result register.
module e2lct_local
   import e2lct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       in_valid,
   output logic       in_stall,
   input  civil_type  civil,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type result
);

   logic [LOCAL_STAGES-1:0] valid_ff, valid_in, hold;

   logic [13:0] y5_c;
   logic [11:0] x_c;
   logic [24:0] q7_prod;
   logic [20:0] q100_prod;
   logic [11:0] wk_full;
   logic [2:0]  wk_c;
   logic [11:0] r100_c;
   logic        leap_c;
   logic        dst_c;
   logic [6:0]  off_c;
   logic [6:0]  h_c;
   civil_type   adj_c;
   result_type  result_in;

   logic [11:0] x0_ff;
   logic [9:0]  q7_0_ff;
   logic [5:0]  q100_0_ff;
   civil_type   civ0_ff, civ1_ff, civ2_ff;
   logic        leap1_ff;
   logic        dst1_ff, dst2_ff;
   result_type  result_ff;

   always_comb begin
      hold[LOCAL_STAGES-1] = valid_ff[LOCAL_STAGES-1] & out_stall;
      for (int i = LOCAL_STAGES - 2; i >= 0; i--) begin
         hold[i] = valid_ff[i] & hold[i+1];
      end
      valid_in = (hold & valid_ff) | (~hold & {valid_ff[LOCAL_STAGES-2:0], in_valid});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      y5_c      = ({2'b0, civil.year} << 2) + {2'b0, civil.year};
      x_c       = 12'(y5_c >> 2) + 12'd1;
      q7_prod   = 25'(x_c) * 25'(MOD7_RECIP);
      q100_prod = 21'(civil.year[11:2]) * 21'(Q100_RECIP);
   end

   always_comb begin
      wk_full = x0_ff - 12'(q7_0_ff) * 12'd7;
      wk_c    = wk_full[2:0];
      r100_c  = civ0_ff.year - 12'(q100_0_ff) * 12'd100;
      leap_c  = ((civ0_ff.year[1:0] == 2'b00) && (r100_c != 12'd0))
             || ((r100_c == 12'd0) && (q100_0_ff[1:0] == 2'b00));
      if (civ0_ff.month inside {[MONTH_APR:MONTH_OCT]}) begin
         dst_c = 1'b1;
      end else if (civ0_ff.month == MONTH_MAR) begin
         dst_c = civ0_ff.day >= (5'd14 - {2'b0, wk_c});
      end else if (civ0_ff.month == MONTH_NOV) begin
         dst_c = civ0_ff.day < (5'd7 - {2'b0, wk_c});
      end else begin
         dst_c = 1'b0;
      end
      dst_c = dst_c & cfg.dst_enable;
   end

   always_comb begin
      off_c = {{2{cfg.utc_offset_hours[4]}}, cfg.utc_offset_hours};
      h_c   = {2'b00, civ1_ff.tod.hour} + off_c + {6'b0, dst1_ff};
      adj_c = civ1_ff;
      if (h_c[6]) begin
         // borrow a day
         adj_c.tod.hour = 5'(h_c + 7'd24);
         if (civ1_ff.day == 5'd1) begin
            if (civ1_ff.month == MONTH_JAN) begin
               adj_c.month = MONTH_DEC;
               adj_c.year  = civ1_ff.year - 12'd1;
            end else begin
               adj_c.month = civ1_ff.month - 4'd1;
            end
            adj_c.day = days_in(adj_c.month, leap1_ff);
         end else begin
            adj_c.day = civ1_ff.day - 5'd1;
         end
      end else if (h_c >= 7'd24) begin
         // carry a day
         adj_c.tod.hour = 5'(h_c - 7'd24);
         if (civ1_ff.day >= days_in(civ1_ff.month, leap1_ff)) begin
            adj_c.day = 5'd1;
            if (civ1_ff.month == MONTH_DEC) begin
               adj_c.month = MONTH_JAN;
               adj_c.year  = civ1_ff.year + 12'd1;
            end else begin
               adj_c.month = civ1_ff.month + 4'd1;
            end
         end else begin
            adj_c.day = civ1_ff.day + 5'd1;
         end
      end else begin
         adj_c.tod.hour = h_c[4:0];
      end
   end

   always_comb begin
      result_in.year       = civ2_ff.year;
      result_in.month      = civ2_ff.month;
      result_in.day        = civ2_ff.day;
      result_in.hour       = civ2_ff.tod.hour;
      result_in.minute     = civ2_ff.tod.minute;
      result_in.second     = civ2_ff.tod.second;
      result_in.pm         = 1'b0;
      result_in.dst_active = dst2_ff;
      if (cfg.twelve_hour_mode) begin
         if (civ2_ff.tod.hour == 5'd0) begin
            result_in.hour = 5'd12;
         end else if (civ2_ff.tod.hour == 5'd12) begin
            result_in.pm = 1'b1;
         end else if (civ2_ff.tod.hour > 5'd12) begin
            result_in.hour = civ2_ff.tod.hour - 5'd12;
            result_in.pm   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!hold[0]) begin
         x0_ff     <= x_c;
         q7_0_ff   <= q7_prod[24:15];
         q100_0_ff <= q100_prod[20:15];
         civ0_ff   <= civil;
      end
      if (!hold[1]) begin
         civ1_ff  <= civ0_ff;
         leap1_ff <= leap_c;
         dst1_ff  <= dst_c;
      end
      if (!hold[2]) begin
         civ2_ff <= adj_c;
         dst2_ff <= dst1_ff;
      end
      if (!hold[3]) begin
         result_ff <= result_in;
      end
   end

   assign in_stall  = hold[0];
   assign out_valid = valid_ff[LOCAL_STAGES-1];
   assign result    = result_ff;

endmodule

FILE: rtl/e2lct_checker.sv
// Port-level checker for epoch_to_local_civil_time, bound to the top level.
// Depends on epoch_to_local_civil_time_defines.svh.
`include "epoch_to_local_civil_time_defines.svh"

module e2lct_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [11:0] rsp_year,
   input logic [3:0]  rsp_month,
   input logic [4:0]  rsp_day,
   input logic [4:0]  rsp_hour,
   input logic [5:0]  rsp_minute,
   input logic [5:0]  rsp_second,
   input logic        rsp_pm,
   input logic        rsp_dst_active
);

   logic [39:0] rsp_fields;

   assign rsp_fields = {rsp_year, rsp_month, rsp_day, rsp_hour, rsp_minute, rsp_second,
                        rsp_pm, rsp_dst_active};

   `E2LCT_ASSERT_NORST(a_reset_empties, clock, reset |=> !rsp_valid, "result valid after reset")

   `E2LCT_ASSERT(a_empty_takes_item, clock, reset, !rsp_valid |-> !req_stall, "stall when empty")

   `E2LCT_ASSERT(a_stall_holds, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fields), "stalled result changed")

   `E2LCT_ASSERT(a_pm_hour, clock, reset, rsp_valid && rsp_pm |-> rsp_hour >= 5'd1 && rsp_hour <= 5'd12, "pm set outside twelve hour form")

endmodule

bind epoch_to_local_civil_time e2lct_checker u_checker (.*);
